@@ design/cse_pkg.sv @@
// shared types and constants of the comb sort engine
`default_nettype none

package cse_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_GAP,
      ST_READ,
      ST_CMP,
      ST_SWAP,
      ST_EREAD,
      ST_EMIT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_ready;
      logic gap_step;
      logic pair_read;
      logic pair_cmp;
      logic pair_swap;
      logic emit_read;
      logic emit_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_last;
      logic pair_ok;
      logic more_passes;
      logic greater;
      logic emit_last;
      logic out_free;
   } status_type;

   // gap shrink: floor(x / 11) as (x * GAP_RECIP) >> GAP_SHIFT, then one correction
   localparam int GAP_SHIFT = 16;
   localparam logic [15:0] GAP_RECIP = 16'd5957;
   localparam int GAP_DIV = 11;

endpackage

`default_nettype wire

@@ design/cse_ram.sv @@
// generic single write port, dual read port ram with registered reads
`default_nettype none

module cse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd0_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd0_addr,
   output logic      [WIDTH-1:0]         rd0_data,
   input  wire logic                     rd1_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd1_addr,
   output logic      [WIDTH-1:0]         rd1_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd0_en) begin
         rd0_ff <= mem_ff[rd0_addr];
      end
      if (rd1_en) begin
         rd1_ff <= mem_ff[rd1_addr];
      end
   end

   assign rd0_data = rd0_ff;
   assign rd1_data = rd1_ff;

endmodule

`default_nettype wire

@@ design/cse_ctrl.sv @@
// controller state machine of the comb sort engine
`default_nettype none

module cse_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cse_pkg::status_type status,
   output cse_pkg::cmd_type         cmd
);

   cse_pkg::state_type state_ff;
   cse_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cse_pkg::ST_LOAD: begin
            if (status.req_last) begin
               state_in = cse_pkg::ST_GAP;
            end
         end
         cse_pkg::ST_GAP: begin
            state_in = cse_pkg::ST_READ;
         end
         cse_pkg::ST_READ: begin
            if (status.pair_ok) begin
               state_in = cse_pkg::ST_CMP;
            end else if (status.more_passes) begin
               state_in = cse_pkg::ST_GAP;
            end else begin
               state_in = cse_pkg::ST_EREAD;
            end
         end
         cse_pkg::ST_CMP: begin
            state_in = status.greater ? cse_pkg::ST_SWAP : cse_pkg::ST_READ;
         end
         cse_pkg::ST_SWAP: begin
            state_in = cse_pkg::ST_READ;
         end
         cse_pkg::ST_EREAD: begin
            state_in = cse_pkg::ST_EMIT;
         end
         cse_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.emit_last ? cse_pkg::ST_LOAD : cse_pkg::ST_EREAD;
            end
         end
         default: begin
            state_in = cse_pkg::ST_LOAD;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         cse_pkg::ST_LOAD:  cmd.load_ready = 1'b1;
         cse_pkg::ST_GAP:   cmd.gap_step   = 1'b1;
         cse_pkg::ST_READ:  cmd.pair_read  = status.pair_ok;
         cse_pkg::ST_CMP:   cmd.pair_cmp   = 1'b1;
         cse_pkg::ST_SWAP:  cmd.pair_swap  = 1'b1;
         cse_pkg::ST_EREAD: cmd.emit_read  = 1'b1;
         cse_pkg::ST_EMIT:  cmd.emit_load  = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cse_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ design/cse_datapath.sv @@
// datapath of the comb sort engine: element store, counters, gap unit, output register
`default_nettype none

module cse_datapath #(
   parameter int MAX_ELEMENTS = 64,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cse_pkg::cmd_type       cmd,
   output cse_pkg::status_type         status,
   input  wire logic                   req_valid,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic                   req_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic      [VALUE_WIDTH-1:0] rsp_value,
   output logic                        rsp_final,
   output logic                        rsp_overflow
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int SW = CW + 1;
   localparam int XW = CW + 3;
   localparam int PW = XW + cse_pkg::GAP_SHIFT;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] gap_ff, gap_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] emit_pos_ff, emit_pos_in;
   logic          swap_ff, swap_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_final_ff, rsp_final_in;
   logic          rsp_overflow_ff, rsp_overflow_in;

   logic                   accept;
   logic                   has_room;
   logic [SW-1:0]          hi_sum;
   logic [AW-1:0]          hi_addr;
   logic                   pair_ok;
   logic                   emit_last;
   logic                   out_free;
   logic                   greater;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   rd0_en;
   logic [AW-1:0]          rd0_addr;
   logic [VALUE_WIDTH-1:0] rd0_data;
   logic [VALUE_WIDTH-1:0] rd1_data;

   logic [XW-1:0] gap_x;
   logic [PW-1:0] gap_prod;
   logic [XW-1:0] gap_q0;
   logic [XW-1:0] gap_rem;
   logic [XW-1:0] gap_q;
   logic [CW-1:0] gap_shrunk;

   // element store
   cse_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd0_en  (rd0_en),
      .rd0_addr(rd0_addr),
      .rd0_data(rd0_data),
      .rd1_en  (cmd.pair_read),
      .rd1_addr(hi_addr),
      .rd1_data(rd1_data)
   );

   // pair and emit bookkeeping
   assign accept    = cmd.load_ready & req_valid;
   assign has_room  = count_ff < CW'(MAX_ELEMENTS);
   assign hi_sum    = SW'(pos_ff) + SW'(gap_ff);
   assign hi_addr   = hi_sum[AW-1:0];
   assign pair_ok   = hi_sum < SW'(count_ff);
   assign emit_last = (SW'(emit_pos_ff) + SW'(1)) == SW'(count_ff);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign greater   = $signed(rd0_data) > $signed(rd1_data);

   // gap shrink: floor(gap * 8 / 11), zero turns into one
   always_comb begin
      gap_x      = {gap_ff, 3'b000};
      gap_prod   = PW'(gap_x) * PW'(cse_pkg::GAP_RECIP);
      gap_q0     = gap_prod[PW-1:cse_pkg::GAP_SHIFT];
      gap_rem    = gap_x - ((gap_q0 << 3) + (gap_q0 << 1) + gap_q0);
      gap_q      = (gap_rem >= XW'(cse_pkg::GAP_DIV)) ? gap_q0 + XW'(1) : gap_q0;
      gap_shrunk = (gap_q == '0) ? CW'(1) : gap_q[CW-1:0];
   end

   // store port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = req_value;
      if (accept) begin
         wr_en = has_room;
      end else if (cmd.pair_cmp) begin
         wr_en   = greater;
         wr_addr = pos_ff;
         wr_data = rd1_data;
      end else if (cmd.pair_swap) begin
         wr_en   = 1'b1;
         wr_addr = hi_addr;
         wr_data = rd0_data;
      end
      rd0_en   = cmd.pair_read | cmd.emit_read;
      rd0_addr = cmd.emit_read ? emit_pos_ff : pos_ff;
   end

   // control state next values
   always_comb begin
      count_in    = count_ff;
      gap_in      = gap_ff;
      pos_in      = pos_ff;
      emit_pos_in = emit_pos_ff;
      swap_in     = swap_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         count_in    = has_room ? count_ff + CW'(1) : count_ff;
         overflow_in = overflow_ff | ~has_room;
         gap_in      = count_in;
      end
      if (cmd.gap_step) begin
         gap_in  = gap_shrunk;
         pos_in  = '0;
         swap_in = 1'b0;
      end
      if (cmd.pair_cmp) begin
         if (greater) begin
            swap_in = 1'b1;
         end else begin
            pos_in = pos_ff + AW'(1);
         end
      end
      if (cmd.pair_swap) begin
         pos_in = pos_ff + AW'(1);
      end
      if (cmd.emit_load) begin
         if (emit_last) begin
            count_in    = '0;
            gap_in      = '0;
            pos_in      = '0;
            swap_in     = 1'b0;
            overflow_in = 1'b0;
            emit_pos_in = '0;
         end else begin
            emit_pos_in = emit_pos_ff + AW'(1);
         end
      end
   end

   // output register next values
   always_comb begin
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_final_in    = rsp_final_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (cmd.emit_load) begin
         rsp_valid_in    = 1'b1;
         rsp_value_in    = rd0_data;
         rsp_final_in    = emit_last;
         rsp_overflow_in = overflow_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gap_ff       <= '0;
         pos_ff       <= '0;
         emit_pos_ff  <= '0;
         swap_ff      <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         gap_ff       <= gap_in;
         pos_ff       <= pos_in;
         emit_pos_ff  <= emit_pos_in;
         swap_ff      <= swap_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_value_ff    <= rsp_value_in;
      rsp_final_ff    <= rsp_final_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign status.req_last    = req_valid & req_last;
   assign status.pair_ok     = pair_ok;
   assign status.more_passes = swap_ff | (gap_ff > CW'(1));
   assign status.greater     = greater;
   assign status.emit_last   = emit_last;
   assign status.out_free    = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_final    = rsp_final_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

`default_nettype wire

@@ design/comb_sort_engine.sv @@
// top level of the comb sort engine
//
// channel   direction  payload
// req_      in         tdata: value; tlast: last element of the set
// rsp_      out        tdata: sorted_value; tlast: final_res; tuser: overflow
//
// loading takes one cycle per request; the sort starts when the request marked last arrives.
// each pass opens with a gap update and closes with a pair read that finds no pair left; each
// compare reads and compares the pair, plus a swap step when the pair swaps (the store has a
// single write port). each result goes through the store read port and the output register.
// reset is synchronous; the store needs no clearing, only counters and flags reset.
// req_tready is low from the last request until the final result sits in the output register.
`default_nettype none

module comb_sort_engine #(
   parameter int MAX_ELEMENTS = 64,
   parameter int VALUE_WIDTH  = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // value
   input  wire logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // sorted_value
   output logic      [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                     rsp_tlast,
   // overflow
   output logic                                     rsp_tuser
);

   localparam int TDW = ((VALUE_WIDTH + 7) / 8) * 8;

   cse_pkg::cmd_type       cmd;
   cse_pkg::status_type    status;
   logic [VALUE_WIDTH-1:0] rsp_value;

   cse_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .status(status),
      .cmd   (cmd)
   );

   cse_datapath #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_valid   (req_tvalid),
      .req_value   (req_tdata[VALUE_WIDTH-1:0]),
      .req_last    (req_tlast),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_value   (rsp_value),
      .rsp_final   (rsp_tlast),
      .rsp_overflow(rsp_tuser)
   );

   assign req_tready = cmd.load_ready;
   assign rsp_tdata  = TDW'(rsp_value);

endmodule

`default_nettype wire
